@@ sv/sbq_pkg.sv @@
// ----------------------------------------------------------------------------
// Stereo biquad package
// Shared widths, coefficient bundle, register indexes and pipeline controls
// for the stereo biquad / resonant-lowpass filter.
// ----------------------------------------------------------------------------
package sbq_pkg;

  // Sample and coefficient formats.
  localparam int unsigned SAMPLE_BITS    = 16;
  localparam int unsigned COEF_BITS      = 32;
  localparam int unsigned COEF_FRAC_BITS = 28;
  localparam int unsigned CFG_IDX_BITS   = 3;

  // Full-precision product and accumulator widths (five products summed).
  localparam int unsigned PROD_BITS = SAMPLE_BITS + COEF_BITS;
  localparam int unsigned ACC_BITS  = PROD_BITS + 4;
  localparam int unsigned RND_BITS  = ACC_BITS + 1 - COEF_FRAC_BITS;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEF_BITS-1:0]   coef_word_t;
  typedef logic signed [PROD_BITS-1:0]   prod_t;
  typedef logic signed [ACC_BITS-1:0]    acc_t;

  // Reset value of the current-input weight: 1.0 in Q3.28.
  localparam coef_word_t FEED0_RESET = coef_word_t'(64'sd1 <<< COEF_FRAC_BITS);

  // Half an output LSB, added before the floor shift.
  localparam logic signed [ACC_BITS:0] ROUND_HALF =
    (ACC_BITS+1)'(64'sd1 <<< (COEF_FRAC_BITS - 1));

  // Saturation limits of an output sample.
  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_FEED0 = 3'd0,
    REG_FEED1 = 3'd1,
    REG_FEED2 = 3'd2,
    REG_BACK1 = 3'd3,
    REG_BACK2 = 3'd4,
    REG_FORM  = 3'd5
  } cfg_reg_e;

  // Coefficient set shared by both lanes.
  typedef struct packed {
    coef_word_t feed0;
    coef_word_t feed1;
    coef_word_t feed2;
    coef_word_t back1;
    coef_word_t back2;
    logic       resonant;
  } coef_t;

  // Pipeline controls from the top level to each lane.
  typedef struct packed {
    logic advance;  // pipeline registers move on
    logic accept;   // a new word enters the first stage
    logic fire;     // the word in the feedback stage completes
  } pipe_ctrl_t;

endpackage

@@ sv/stereo_biquad_iir_filter.sv @@
// ----------------------------------------------------------------------------
// Stereo biquad IIR filter
// An accepted sample pair passes the product and sum registers into the merge output register.
// Throughput: one pair per cycle unless the skid register holds; the limit is the
// feedback stage, where the newest output passes through one multiplier and the rounding add each cycle.
// Reset clears all channel history and loads the coefficient defaults
// (unity feed-forward gain, biquad form); no clearing pass is needed.
// ----------------------------------------------------------------------------
module stereo_biquad_iir_filter
  import sbq_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  sample_t                 left_sample_i,
  input  sample_t                 right_sample_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output sample_t                 left_filtered_o,
  output sample_t                 right_filtered_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [COEF_BITS-1:0]    cfg_data_i
);

  coef_t      coef_q;
  pipe_ctrl_t ctrl;
  logic       v1_q, v2_q;
  logic       full;
  sample_t    left_y, right_y;

  // Configuration registers; writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.feed0    <= FEED0_RESET;
      coef_q.feed1    <= '0;
      coef_q.feed2    <= '0;
      coef_q.back1    <= '0;
      coef_q.back2    <= '0;
      coef_q.resonant <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_FEED0: coef_q.feed0    <= cfg_data_i;
        REG_FEED1: coef_q.feed1    <= cfg_data_i;
        REG_FEED2: coef_q.feed2    <= cfg_data_i;
        REG_BACK1: coef_q.back1    <= cfg_data_i;
        REG_BACK2: coef_q.back2    <= cfg_data_i;
        REG_FORM:  coef_q.resonant <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Pipeline control: everything moves unless the skid register is holding.
  always_comb begin
    ctrl.advance = !full;
    ctrl.accept  = in_valid_i && !full;
    ctrl.fire    = v2_q && !full;
  end

  assign in_stall_o = full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (ctrl.advance) begin
      v1_q <= ctrl.accept;
      v2_q <= v1_q;
    end
  end

  // Two identical lanes, one per channel.
  sbq_lane u_lane_left (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .coef_i   (coef_q),
    .sample_i (left_sample_i),
    .y_o      (left_y)
  );

  sbq_lane u_lane_right (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .coef_i   (coef_q),
    .sample_i (right_sample_i),
    .y_o      (right_y)
  );

  // Merge both lanes into the result word.
  sbq_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (ctrl.fire),
    .left_i      (left_y),
    .right_i     (right_y),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .left_o      (left_filtered_o),
    .right_o     (right_filtered_o),
    .full_o      (full)
  );

endmodule

@@ sv/sbq_lane.sv @@
// ----------------------------------------------------------------------------
// Filter lane
// One channel of the filter: feed-forward products, their sum, and the
// feedback stage with rounding, saturation and history.
// ----------------------------------------------------------------------------
module sbq_lane
  import sbq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  pipe_ctrl_t ctrl_i,
  input  coef_t      coef_i,
  input  sample_t    sample_i,
  output sample_t    y_o
);

  // Signed sample by coefficient at full precision.
  function automatic prod_t mul_sc(sample_t a, coef_word_t b);
    return PROD_BITS'(a) * PROD_BITS'(b);
  endfunction

  // Round half up to sample units, then saturate.
  function automatic sample_t round_sat(acc_t a);
    logic signed [ACC_BITS:0] v;
    logic signed [RND_BITS-1:0] r;
    v = (ACC_BITS+1)'(a) + ROUND_HALF;
    r = v[ACC_BITS:COEF_FRAC_BITS];
    if (r > RND_BITS'(SAMPLE_MAX)) begin
      return SAMPLE_MAX;
    end else if (r < RND_BITS'(SAMPLE_MIN)) begin
      return SAMPLE_MIN;
    end
    return r[SAMPLE_BITS-1:0];
  endfunction

  sample_t in_d1_q, in_d2_q, out_d1_q, out_d2_q;
  prod_t   p0_q, p1_q, p2_q, pb2_q;
  acc_t    ffs_q, ffr_q;
  sample_t mul1_a;
  acc_t    fb_sum, acc_out, acc_state;
  sample_t y_round, state_round;

  // In resonant form the second multiplier weighs the current input instead.
  assign mul1_a = coef_i.resonant ? sample_i : in_d1_q;

  // Input history, advanced per accepted word in biquad form only.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_d1_q <= '0;
      in_d2_q <= '0;
    end else if (ctrl_i.accept && !coef_i.resonant) begin
      in_d1_q <= sample_i;
      in_d2_q <= in_d1_q;
    end
  end

  // Stage one: feed-forward products.  Stage two: their sums.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.advance) begin
      p0_q  <= mul_sc(sample_i, coef_i.feed0);
      p1_q  <= mul_sc(mul1_a, coef_i.feed1);
      p2_q  <= mul_sc(in_d2_q, coef_i.feed2);
      ffs_q <= coef_i.resonant ? ACC_BITS'(p0_q)
                               : ACC_BITS'(p0_q) + ACC_BITS'(p1_q) + ACC_BITS'(p2_q);
      ffr_q <= ACC_BITS'(p0_q) - ACC_BITS'(p1_q);
    end
  end

  // Feedback stage: the older output term is taken from a product registered
  // in the cycle before, so only the newest output passes through a multiplier.
  always_comb begin
    fb_sum      = ACC_BITS'(mul_sc(out_d1_q, coef_i.back1)) + ACC_BITS'(pb2_q);
    acc_out     = ffs_q + fb_sum;
    acc_state   = ffr_q + fb_sum;
    y_round     = round_sat(acc_out);
    state_round = round_sat(acc_state);
  end

  assign y_o = y_round;

  // Output history and the prepared product of the older output.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_d1_q <= '0;
      out_d2_q <= '0;
      pb2_q    <= '0;
    end else begin
      if (ctrl_i.fire) begin
        out_d1_q <= coef_i.resonant ? state_round : y_round;
        out_d2_q <= out_d1_q;
      end
      pb2_q <= mul_sc(ctrl_i.fire ? out_d1_q : out_d2_q, coef_i.back2);
    end
  end

endmodule

@@ sv/sbq_merge.sv @@
// ----------------------------------------------------------------------------
// Result merge stage
// Joins the two lane outputs into one result word and holds it in an output
// register backed by a skid register, so the pipeline stalls on a register.
// ----------------------------------------------------------------------------
module sbq_merge
  import sbq_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  sample_t left_i,
  input  sample_t right_i,
  input  logic    out_stall_i,
  output logic    out_valid_o,
  output sample_t left_o,
  output sample_t right_o,
  output logic    full_o
);

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  sample_t out_left_q, out_right_q, skid_left_q, skid_right_q;
  logic    drain, load_out, load_skid, from_skid;

  // Hand-off decisions for the output and skid registers.
  always_comb begin
    drain        = out_valid_q && !out_stall_i;
    from_skid    = skid_valid_q && drain;
    load_out     = push_i && (!out_valid_q || drain);
    load_skid    = push_i && out_valid_q && !drain;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (from_skid) begin
      skid_valid_d = 1'b0;
    end else if (load_out) begin
      out_valid_d = 1'b1;
    end else if (load_skid) begin
      skid_valid_d = 1'b1;
    end else if (drain) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (from_skid) begin
      out_left_q  <= skid_left_q;
      out_right_q <= skid_right_q;
    end else if (load_out) begin
      out_left_q  <= left_i;
      out_right_q <= right_i;
    end
    if (load_skid) begin
      skid_left_q  <= left_i;
      skid_right_q <= right_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign left_o      = out_left_q;
  assign right_o     = out_right_q;
  assign full_o      = skid_valid_q;

endmodule

@@ test/stereo_biquad_iir_filter_tb.sv @@
// ----------------------------------------------------------------------------
// Stereo biquad IIR filter testbench
// Feeds stereo sample pairs through the filter under many coefficient sets in
// both filter forms. A scoreboard predicts each filtered pair from its own copy
// of the channel history and compares it with what the block delivers. The
// sender works in bursts and the receiver stalls on patterns of its own.
// ----------------------------------------------------------------------------
module stereo_biquad_iir_filter_tb
  import sbq_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT     = 300000;
  localparam int SETTLE_CYCLES   = 8;
  localparam int RAND_PHASES     = 10;
  localparam int PAIRS_PER_PHASE = 165;
  localparam int HOLD_PERIOD     = 2500;
  localparam int HOLD_START      = 700;
  localparam int HOLD_LEN        = 150;

  // Indexes past the register list; the block must ignore them.
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_HI = 3'd7;

  localparam longint ACC_MAX    = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint ACC_MIN    = -64'sh7FFF_FFFF_FFFF_FFFF - 64'sd1;
  localparam longint ROUND_BIAS = longint'(1) <<< (COEF_FRAC_BITS - 1);

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  typedef struct {
    sample_t left;
    sample_t right;
  } stereo_word_t;

  typedef struct {
    sample_t in_d1;
    sample_t in_d2;
    sample_t out_d1;
    sample_t out_d2;
  } lane_hist_t;

  // Block ports.
  logic                    clk_i          = 1'b0;
  logic                    rst_ni         = 1'b0;
  logic                    in_valid_i     = 1'b0;
  logic                    in_stall_o;
  sample_t                 left_sample_i  = '0;
  sample_t                 right_sample_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i    = 1'b0;
  sample_t                 left_filtered_o;
  sample_t                 right_filtered_o;
  logic                    cfg_valid_i    = 1'b0;
  logic                    cfg_ready_o;
  logic [CFG_IDX_BITS-1:0] cfg_index_i    = '0;
  logic [COEF_BITS-1:0]    cfg_data_i     = '0;

  // Scoreboard state: coefficients, per-lane history and expected pairs.
  coef_t        coefs;
  lane_hist_t   hist [2];
  stereo_word_t filtered_pair_q[$];
  stereo_word_t pending_pair_q[$];

  int pairs_queued   = 0;
  int pairs_accepted = 0;
  int pairs_checked  = 0;
  int settings_used  = 0;
  int error_count    = 0;
  int cycle_count    = 0;

  // Sender and receiver pacing.
  int          burst_left = 0;
  int          gap_left   = 0;
  int          hold_timer = 0;
  logic        hold_on    = 1'b0;
  stall_mode_e stall_mode = STALL_NONE;
  int          stall_mode_left = 0;

  stereo_biquad_iir_filter dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .left_sample_i    (left_sample_i),
    .right_sample_i   (right_sample_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .left_filtered_o  (left_filtered_o),
    .right_filtered_o (right_filtered_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  // 4 ns clock.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Accumulator add that clips at the 64-bit signed limits.
  function automatic longint sat_add(longint a, longint b);
    longint s;
    s = a + b;
    if (!a[63] && !b[63] && s[63]) return ACC_MAX;
    if (a[63] && b[63] && !s[63]) return ACC_MIN;
    return s;
  endfunction

  // Round half up to whole sample units, then clip to the sample range.
  function automatic sample_t round_clip(longint acc);
    longint r;
    r = sat_add(acc, ROUND_BIAS) >>> COEF_FRAC_BITS;
    if (r > longint'(SAMPLE_MAX)) return SAMPLE_MAX;
    if (r < longint'(SAMPLE_MIN)) return SAMPLE_MIN;
    return sample_t'(r);
  endfunction

  // One channel of the filter; updates that channel's history.
  function automatic sample_t filter_lane(int lane, sample_t x);
    longint  acc;
    longint  xv;
    sample_t y;
    xv  = longint'(x);
    acc = xv * longint'($signed(coefs.feed0));
    acc = sat_add(acc, longint'(hist[lane].out_d1) * longint'($signed(coefs.back1)));
    acc = sat_add(acc, longint'(hist[lane].out_d2) * longint'($signed(coefs.back2)));
    if (coefs.resonant) begin
      // Resonant form: input delays untouched, stored state is the highpass part.
      y = round_clip(acc);
      hist[lane].out_d2 = hist[lane].out_d1;
      hist[lane].out_d1 = round_clip(sat_add(acc, -(xv * longint'($signed(coefs.feed1)))));
    end else begin
      acc = sat_add(acc, longint'(hist[lane].in_d1) * longint'($signed(coefs.feed1)));
      acc = sat_add(acc, longint'(hist[lane].in_d2) * longint'($signed(coefs.feed2)));
      y = round_clip(acc);
      hist[lane].out_d2 = hist[lane].out_d1;
      hist[lane].out_d1 = y;
      hist[lane].in_d2  = hist[lane].in_d1;
      hist[lane].in_d1  = x;
    end
    return y;
  endfunction

  // Sender: bursts of random length with random gaps; the payload holds while stalled.
  always @(posedge clk_i) begin : drive_proc
    stereo_word_t next_word;
    stereo_word_t filtered;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        filtered.left  = filter_lane(0, left_sample_i);
        filtered.right = filter_lane(1, right_sample_i);
        filtered_pair_q.push_back(filtered);
        pairs_accepted++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left   <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (pending_pair_q.size() > 0) begin
          next_word      = pending_pair_q.pop_front();
          in_valid_i     <= 1'b1;
          left_sample_i  <= next_word.left;
          right_sample_i <= next_word.right;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Long hold-off on the receiver, counted here, so the block backs up.
  always @(posedge clk_i) begin
    hold_timer <= (hold_timer == HOLD_PERIOD - 1) ? 0 : hold_timer + 1;
    hold_on    <= (hold_timer >= HOLD_START) && (hold_timer < HOLD_START + HOLD_LEN);
  end

  // Receiver stall pattern: modes of random length, plus the hold-off.
  always @(posedge clk_i) begin : stall_proc
    logic pat;
    if (stall_mode_left == 0) begin
      stall_mode      <= stall_mode_e'($urandom_range(0, 3));
      stall_mode_left <= $urandom_range(16, 200);
    end else begin
      stall_mode_left <= stall_mode_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  pat = 1'b0;
      STALL_LIGHT: pat = ($urandom_range(0, 3) == 0);
      STALL_HEAVY: pat = ($urandom_range(0, 3) != 0);
      default:     pat = cycle_count[2];
    endcase
    out_stall_i <= hold_on || pat;
  end

  // Monitor: each delivered word is checked against the oldest expected pair.
  always @(posedge clk_i) begin : check_proc
    stereo_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (filtered_pair_q.size() == 0) begin
        $error("filtered word with nothing expected: left %0d right %0d",
               left_filtered_o, right_filtered_o);
        error_count++;
      end else begin
        want = filtered_pair_q.pop_front();
        if (left_filtered_o !== want.left) begin
          $error("left_filtered mismatch: expected %0d, actual %0d",
                 want.left, left_filtered_o);
          error_count++;
        end
        if (right_filtered_o !== want.right) begin
          $error("right_filtered mismatch: expected %0d, actual %0d",
                 want.right, right_filtered_o);
          error_count++;
        end
        pairs_checked++;
      end
    end
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $error("run timed out after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Register write; called just after a rising edge, returns at the edge that takes it.
  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [COEF_BITS-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_FEED0: coefs.feed0    = data;
      REG_FEED1: coefs.feed1    = data;
      REG_FEED2: coefs.feed2    = data;
      REG_BACK1: coefs.back1    = data;
      REG_BACK2: coefs.back2    = data;
      REG_FORM:  coefs.resonant = data[0];
      default: ;
    endcase
  endtask

  // Loads a full coefficient set, sometimes with a write to an unused index.
  task automatic apply_setting(logic [31:0] f0, logic [31:0] f1, logic [31:0] f2,
                               logic [31:0] b1, logic [31:0] b2, logic form);
    write_reg(REG_FEED0, f0);
    write_reg(REG_FEED1, f1);
    write_reg(REG_FEED2, f2);
    write_reg(REG_BACK1, b1);
    write_reg(REG_BACK2, b2);
    write_reg(REG_FORM, {31'($urandom), form});
    if ($urandom_range(0, 3) == 0) begin
      write_reg($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO, $urandom);
    end
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  task automatic queue_pair(sample_t l, sample_t r);
    stereo_word_t w;
    w.left  = l;
    w.right = r;
    pending_pair_q.push_back(w);
    pairs_queued++;
  endtask

  // Waits until every queued pair is taken and every result has come, then settles.
  task automatic wait_idle();
    while (pairs_accepted != pairs_queued || filtered_pair_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Coefficients weighted towards usable filters, with raw and extreme values mixed in.
  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 9))
      0:       return $urandom;
      1, 2: begin
        case ($urandom_range(0, 4))
          0:       return 32'h7FFF_FFFF;
          1:       return 32'h8000_0000;
          2:       return 32'h0000_0000;
          3:       return 32'hFFFF_FFFF;
          default: return 32'h1000_0000;
        endcase
      end
      3, 4, 5, 6: return 32'($urandom_range(0, 1 << 28)) - 32'(1 << 27);
      default:    return 32'($urandom_range(0, 1 << 30)) - 32'(1 << 29);
    endcase
  endfunction

  function automatic sample_t rand_sample();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0:       return SAMPLE_MAX;
          1:       return SAMPLE_MIN;
          2:       return '0;
          default: return '1;
        endcase
      end
      1:       return sample_t'($urandom_range(0, 128)) - sample_t'(64);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Stimulus and end of run.
  initial begin
    logic mono;
    coefs.feed0    = FEED0_RESET;
    coefs.feed1    = '0;
    coefs.feed2    = '0;
    coefs.back1    = '0;
    coefs.back2    = '0;
    coefs.resonant = 1'b0;
    for (int i = 0; i < 2; i++) begin
      hist[i] = '{default: '0};
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset defaults: unity pass-through, sample extremes.
    queue_pair('0, '0);
    queue_pair(SAMPLE_MAX, SAMPLE_MIN);
    queue_pair(SAMPLE_MIN, SAMPLE_MAX);
    queue_pair('1, 16'sd1);
    queue_pair(16'sh5555, 16'shAAAA);
    queue_pair(16'shAAAA, 16'sh5555);
    wait_idle();

    // Extreme coefficients drive the output into saturation both ways.
    apply_setting(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    queue_pair(SAMPLE_MAX, SAMPLE_MIN);
    queue_pair(SAMPLE_MIN, SAMPLE_MAX);
    queue_pair(SAMPLE_MAX, SAMPLE_MAX);
    queue_pair(SAMPLE_MIN, SAMPLE_MIN);
    queue_pair('0, '0);
    queue_pair(16'sd1, '1);
    wait_idle();

    // Resonant form: state takes the highpass remainder; the last two pairs are mono on the left lane.
    apply_setting(32'h0800_0000, 32'h0400_0000, 32'h7FFF_FFFF,
                  32'h1800_0000, 32'hF400_0000, 1'b1);
    queue_pair(16'sd1000, -16'sd1000);
    queue_pair(SAMPLE_MAX, SAMPLE_MIN);
    queue_pair('0, '0);
    queue_pair('0, '0);
    queue_pair(-16'sd20000, 16'sd5);
    queue_pair(16'sd12345, '0);
    queue_pair(SAMPLE_MAX, '0);
    wait_idle();

    // Switch back to biquad form with the history kept; unused indexes are ignored.
    write_reg(REG_FORM, 32'h0000_0000);
    write_reg(CFG_SPARE_LO, 32'hFFFF_FFFF);
    write_reg(CFG_SPARE_HI, 32'hFFFF_FFFF);
    cfg_valid_i <= 1'b0;
    settings_used++;
    queue_pair(16'sd100, -16'sd100);
    queue_pair('0, '0);
    queue_pair(SAMPLE_MIN, SAMPLE_MAX);
    queue_pair(16'sd2, 16'sd3);
    wait_idle();

    // Random phases, each under a fresh coefficient set.
    for (int p = 0; p < RAND_PHASES; p++) begin
      apply_setting(rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                    1'($urandom_range(0, 1)));
      mono = ($urandom_range(0, 4) == 0);
      for (int n = 0; n < PAIRS_PER_PHASE; n++) begin
        queue_pair(rand_sample(), mono ? sample_t'(0) : rand_sample());
      end
      wait_idle();
    end

    $display("Run covered %0d sample pairs under %0d coefficient settings in both forms;",
             pairs_accepted, settings_used);
    $display("%0d filtered pairs compared, %0d errors.", pairs_checked, error_count);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
